// ===== hw/rtl/hdlc_mfr_pkg.sv =====
// ----------------------------------------------------------------------------
// hdlc_mfr_pkg
// Shared constants and the bytewise crc-16/x.25 update for the hdlc meter
// frame receiver.
// ----------------------------------------------------------------------------
package hdlc_mfr_pkg;

    localparam int BUFFER_BYTES_DEF   = 512;
    localparam int MAX_ADDR_BYTES_DEF = 3;

    localparam int LEN_W      = 12;
    localparam int ADDR_CNT_W = 3;
    localparam int HDR_FIXED  = 6;

    localparam logic [7:0]            FLAG_BYTE    = 8'h7E;
    localparam logic [7:0]            FORMAT_MASK  = 8'hF0;
    localparam logic [7:0]            FORMAT_RESET = 8'hA0;
    localparam logic [3:0]            LEN_HI_MASK  = 4'hF;
    localparam logic [ADDR_CNT_W-1:0] ADDR_CNT_MAX = 3'd7;

    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'h8408;
    localparam logic [15:0] CRC_XOROUT = 16'hFFFF;

    // one byte of the reflected crc, lsb first
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [ADDR_CNT_W-1:0] sat_inc(input logic [ADDR_CNT_W-1:0] c);
        return (c == ADDR_CNT_MAX) ? ADDR_CNT_MAX : c + 1'b1;
    endfunction

endpackage

// ===== hw/rtl/hdlc_mfr_parser.sv =====
// ----------------------------------------------------------------------------
// hdlc_mfr_parser
// Frame state for the receiver: flag hunt, format and length decode, address
// collection, header and frame crc checks, stop flag detection.
// ----------------------------------------------------------------------------
module hdlc_mfr_parser
    import hdlc_mfr_pkg::*;
#(
    parameter int BUFFER_BYTES   = BUFFER_BYTES_DEF,
    parameter int MAX_ADDR_BYTES = MAX_ADDR_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] data_byte,
    input  logic [7:0] expected_format,
    output logic       frame_done
);

    localparam int POS_W = $clog2(BUFFER_BYTES + 1);
    localparam int CMP_W = (POS_W > LEN_W + 1) ? POS_W : LEN_W + 1;

    logic [POS_W-1:0]      pos_reg,   pos_next;
    logic [LEN_W-1:0]      flen_reg,  flen_next;
    logic [ADDR_CNT_W-1:0] dcnt_reg,  dcnt_next;
    logic [ADDR_CNT_W-1:0] scnt_reg,  scnt_next;
    logic                  ddone_reg, ddone_next;
    logic                  sdone_reg, sdone_next;
    logic [15:0]           crc_reg,   crc_next;
    logic [7:0]            rb0_reg,   rb0_next;
    logic [7:0]            rb1_reg,   rb1_next;

    logic                  wrap;
    logic                  take;
    logic [POS_W-1:0]      e_pos;
    logic [LEN_W-1:0]      e_flen;
    logic [ADDR_CNT_W-1:0] e_dcnt, e_scnt;
    logic                  e_ddone, e_sdone;
    logic [15:0]           e_crc;
    logic [7:0]            e_rb0, e_rb1;
    logic [15:0]           crc_cap;
    logic [POS_W-1:0]      np;
    logic [CMP_W-1:0]      np_w, hdr_pos, fcs_pos, stop_pos;
    logic                  crc_ok;
    logic                  fail;
    logic                  done_now;
    logic [LEN_W-1:0]      n_flen;
    logic [ADDR_CNT_W-1:0] n_dcnt, n_scnt;
    logic                  n_ddone, n_sdone;

    always_comb
    begin
        // finished frame or full buffer: start over and take this byte as byte 0
        wrap = ((flen_reg != '0) && (CMP_W'(pos_reg) >= CMP_W'(flen_reg) + CMP_W'(2)))
            || (CMP_W'(pos_reg) >= CMP_W'(BUFFER_BYTES));

        e_pos   = wrap ? '0 : pos_reg;
        e_flen  = wrap ? '0 : flen_reg;
        e_dcnt  = wrap ? '0 : dcnt_reg;
        e_scnt  = wrap ? '0 : scnt_reg;
        e_ddone = wrap ? 1'b0 : ddone_reg;
        e_sdone = wrap ? 1'b0 : sdone_reg;
        e_crc   = wrap ? CRC_INIT : crc_reg;
        e_rb0   = wrap ? 8'h00 : rb0_reg;
        e_rb1   = wrap ? 8'h00 : rb1_reg;

        take = step
            && !((pos_reg == '0) && (data_byte != FLAG_BYTE))
            && !(!wrap && (pos_reg == POS_W'(1)) && (data_byte == FLAG_BYTE));

        // crc runs two bytes behind so the fcs bytes can be compared
        crc_cap  = (e_pos >= POS_W'(3)) ? crc_feed(e_crc, e_rb1) : e_crc;
        np       = e_pos + 1'b1;
        np_w     = CMP_W'(np);
        hdr_pos  = CMP_W'(HDR_FIXED) + CMP_W'(e_dcnt) + CMP_W'(e_scnt);
        fcs_pos  = CMP_W'(e_flen) + CMP_W'(1);
        stop_pos = CMP_W'(e_flen) + CMP_W'(2);
        crc_ok   = ((crc_cap ^ CRC_XOROUT) == {data_byte, e_rb0});

        fail     = 1'b0;
        done_now = 1'b0;
        n_flen   = e_flen;
        n_dcnt   = e_dcnt;
        n_scnt   = e_scnt;
        n_ddone  = e_ddone;
        n_sdone  = e_sdone;

        if (np == POS_W'(1))
        begin
            fail = 1'b0;
        end
        else if (np == POS_W'(2))
        begin
            fail = ((data_byte & FORMAT_MASK) != expected_format);
        end
        else if (np == POS_W'(3))
        begin
            n_flen = {e_rb0[3:0] & LEN_HI_MASK, data_byte};
        end
        else if (!e_ddone)
        begin
            n_dcnt = sat_inc(e_dcnt);
            if (data_byte[0])
            begin
                n_ddone = 1'b1;
                fail    = (n_dcnt > ADDR_CNT_W'(MAX_ADDR_BYTES));
            end
        end
        else if (!e_sdone)
        begin
            n_scnt = sat_inc(e_scnt);
            if (data_byte[0])
            begin
                n_sdone = 1'b1;
                fail    = (n_scnt > ADDR_CNT_W'(MAX_ADDR_BYTES));
            end
        end
        else if (np_w == hdr_pos)
        begin
            fail = !crc_ok;
        end
        else if (np_w == fcs_pos)
        begin
            fail = !crc_ok;
        end
        else if (np_w == stop_pos)
        begin
            if (data_byte == FLAG_BYTE)
            begin
                done_now = 1'b1;
            end
            else
            begin
                fail = 1'b1;
            end
        end

        if (fail)
        begin
            pos_next   = '0;
            flen_next  = '0;
            dcnt_next  = '0;
            scnt_next  = '0;
            ddone_next = 1'b0;
            sdone_next = 1'b0;
            crc_next   = CRC_INIT;
            rb0_next   = 8'h00;
            rb1_next   = 8'h00;
        end
        else
        begin
            pos_next   = np;
            flen_next  = n_flen;
            dcnt_next  = n_dcnt;
            scnt_next  = n_scnt;
            ddone_next = n_ddone;
            sdone_next = n_sdone;
            crc_next   = crc_cap;
            rb0_next   = data_byte;
            rb1_next   = e_rb0;
        end

        frame_done = take && done_now;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            flen_reg  <= '0;
            dcnt_reg  <= '0;
            scnt_reg  <= '0;
            ddone_reg <= 1'b0;
            sdone_reg <= 1'b0;
            crc_reg   <= CRC_INIT;
            rb0_reg   <= 8'h00;
            rb1_reg   <= 8'h00;
        end
        else if (take)
        begin
            pos_reg   <= pos_next;
            flen_reg  <= flen_next;
            dcnt_reg  <= dcnt_next;
            scnt_reg  <= scnt_next;
            ddone_reg <= ddone_next;
            sdone_reg <= sdone_next;
            crc_reg   <= crc_next;
            rb0_reg   <= rb0_next;
            rb1_reg   <= rb1_next;
        end
    end

endmodule

// ===== hw/rtl/hdlc_meter_frame_receiver_core.sv =====
// ----------------------------------------------------------------------------
// hdlc_meter_frame_receiver_core
// Byte-wise receiver and checker for hdlc format type 3 meter frames.
// ----------------------------------------------------------------------------
// usage:
//   input channel: in_valid / in_stall with data_byte, one link byte per
//   transaction. every accepted byte yields exactly one output transaction
//   on out_valid / out_stall carrying frame_done, which is 1 only for the
//   stop flag of a frame whose format, addresses, header crc and frame crc
//   all passed.
//   frame_done is registered, in the output register or the skid entry.
//   throughput: one byte per cycle while in_stall is low; the byte-wise crc
//   update and the position compares all finish in the accept cycle of the parser.
//   the user writes expected_format via cfg_wr_en / cfg_wr_data while idle; not enforced.
//   reset: the frame state returns to flag hunt, expected_format to 0xa0,
//   and the output buffer empties.
//   stall: a two-entry output buffer (output register plus skid) keeps one
//   byte flowing while out_stall is high; in_stall rises only once the skid
//   entry is occupied.
// ----------------------------------------------------------------------------
module hdlc_meter_frame_receiver_core
    import hdlc_mfr_pkg::*;
#(
    parameter int BUFFER_BYTES   = BUFFER_BYTES_DEF,
    parameter int MAX_ADDR_BYTES = MAX_ADDR_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       frame_done
);

    logic [7:0] expected_format_reg;
    logic       out_valid_reg;
    logic       out_done_reg;
    logic       skid_valid_reg;
    logic       skid_done_reg;
    logic       push;
    logic       pop;
    logic       done_calc;

    assign in_stall   = skid_valid_reg;
    assign push       = in_valid && !in_stall;
    assign pop        = out_valid_reg && !out_stall;
    assign out_valid  = out_valid_reg;
    assign frame_done = out_done_reg;

    hdlc_mfr_parser #(
        .BUFFER_BYTES   (BUFFER_BYTES),
        .MAX_ADDR_BYTES (MAX_ADDR_BYTES)
    ) u_parser (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (push),
        .data_byte       (data_byte),
        .expected_format (expected_format_reg),
        .frame_done      (done_calc)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_format_reg <= FORMAT_RESET;
        end
        else if (cfg_wr_en)
        begin
            expected_format_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_done_reg <= skid_done_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_done_reg <= done_calc;
            end
            else
            begin
                out_done_reg <= done_calc;
            end
        end
    end

endmodule
